>>> src/drs_pkg.sv
`default_nettype none
// ============================================================================
// drs_pkg
// Shared types and constants for the directional recursive smoother.
// ============================================================================
package drs_pkg;

   localparam int MAX_SIDE         = 256;
   localparam int SAMPLE_BITS      = 32;
   localparam int FACTOR_FRAC_BITS = 16;

   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
   localparam int USED_W      = 2 * SIDE_W;
   localparam int FACTOR_W    = FACTOR_FRAC_BITS + 1;
   localparam int DIFF_W      = SAMPLE_BITS + 1;
   localparam int PROD_W      = DIFF_W + FACTOR_W + 1;

   localparam int INDEX_W  = 16;
   localparam int VALUE_W  = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [FACTOR_W-1:0] FACTOR_ONE   = FACTOR_W'(1) << FACTOR_FRAC_BITS;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(32768);
   localparam logic [SIDE_W-1:0]   SIDE_MAX     = SIDE_W'(MAX_SIDE);

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_PASS  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      DIR_FROM_ABOVE = 2'd0,
      DIR_FROM_BELOW = 2'd1,
      DIR_FROM_RIGHT = 2'd2,
      DIR_FROM_LEFT  = 2'd3
   } direction_type;

   typedef enum logic [1:0] {
      CSR_FACTOR  = 2'd0,
      CSR_COLUMNS = 2'd1,
      CSR_ROWS    = 2'd2,
      CSR_UNUSED  = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_READ_DATA = 1'b0,
      KIND_PASS_DONE = 1'b1
   } result_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PRIME,
      ST_READ,
      ST_MUL,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage : drs_pkg
`default_nettype wire

>>> src/directional_recursive_smoother_unit.sv
`default_nettype none
// ============================================================================
// directional_recursive_smoother_unit
// Tile store of Q16.16 height samples with a directional one-pole smoothing
// pass, run by a small sequencer around one shared multiplier.
// ============================================================================
//  channel   ports                                  handshake
//  request   req_opcode/direction/index/value       start & !busy
//  result    rsp_result_kind, rsp_read_value        rsp_valid, one cycle
//  csr       csr_index, csr_wdata                   csr_valid & csr_ready
//
//  In-range writes are stored on accept; read beats return data on the next
//  cycle and both can follow every cycle while not busy. A pass is bound by
//  the single store read port and the shared multiplier: each line runs load
//  and prime, then read, multiply and write per further sample; the done
//  state carries the completion strobe, and an empty tile goes to done.
//  Synchronous reset sets control and csr registers only; the store holds
//  no reset value. The receiver cannot stall; rsp_valid lasts one cycle.
// ============================================================================
module directional_recursive_smoother_unit
   import drs_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_opcode,
   input  wire logic [1:0]                 req_pass_direction,
   input  wire logic [INDEX_W-1:0]         req_sample_index,
   input  wire logic signed [VALUE_W-1:0]  req_sample_value,
   output logic                            rsp_valid,
   output logic                            rsp_result_kind,
   output logic signed [VALUE_W-1:0]       rsp_read_value,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wdata
);

   state_type                     state_ff, state_in;
   logic [FACTOR_W-1:0]           factor_ff;
   logic [SIDE_W-1:0]             cols_ff, rows_ff;
   logic [1:0]                    dir_ff, dir_in;
   logic [ADDR_W-1:0]             addr_ff, addr_in;
   logic [ADDR_W-1:0]             line_start_ff, line_start_in;
   logic [SIDE_W-1:0]             line_cnt_ff, line_cnt_in;
   logic [SIDE_W-1:0]             elem_cnt_ff, elem_cnt_in;
   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_BITS-1:0] cur_ff, cur_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic                          rd_pend_ff, rd_pend_in;
   logic                          rd_ok_ff, rd_ok_in;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   logic signed [SAMPLE_BITS-1:0] tile_mem [STORE_DEPTH];

   logic                          mem_we;
   logic [ADDR_W-1:0]             mem_wa, mem_ra;
   logic signed [SAMPLE_BITS-1:0] mem_wd;

   logic                          accept;
   logic [USED_W-1:0]             used;
   logic                          idx_ok;
   logic [ADDR_W-1:0]             req_addr;
   logic signed [DIFF_W-1:0]      diff;
   logic signed [SAMPLE_BITS-1:0] blend_value;
   logic                          elem_neg;
   logic [ADDR_W-1:0]             elem_stride, line_step, addr_step;
   logic [ADDR_W-1:0]             next_line_start;
   logic [ADDR_W-1:0]             init_start;
   logic [SIDE_W-1:0]             init_lines, init_len, len_now;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign used     = USED_W'(cols_ff) * USED_W'(rows_ff);
   assign idx_ok   = USED_W'(req_sample_index) < used;
   assign req_addr = req_sample_index[ADDR_W-1:0];

   // blend: cur + floor(f * (prev - cur) / 2^F)
   assign diff        = DIFF_W'(prev_ff) - DIFF_W'(rd_data_ff);
   assign prod_in     = PROD_W'(diff) * PROD_W'($signed({1'b0, factor_ff}));
   assign blend_value = cur_ff + prod_ff[FACTOR_FRAC_BITS +: SAMPLE_BITS];

   always_comb begin
      elem_neg    = 1'b0;
      elem_stride = ADDR_W'(cols_ff);
      line_step   = ADDR_W'(1);
      len_now     = rows_ff;
      case (direction_type'(dir_ff))
         DIR_FROM_ABOVE: begin
            elem_neg = 1'b0;
         end
         DIR_FROM_BELOW: begin
            elem_neg = 1'b1;
         end
         DIR_FROM_RIGHT: begin
            elem_neg    = 1'b1;
            elem_stride = ADDR_W'(1);
            line_step   = ADDR_W'(cols_ff);
            len_now     = cols_ff;
         end
         default: begin
            elem_stride = ADDR_W'(1);
            line_step   = ADDR_W'(cols_ff);
            len_now     = cols_ff;
         end
      endcase
   end

   assign addr_step       = elem_neg ? addr_ff - elem_stride : addr_ff + elem_stride;
   assign next_line_start = line_start_ff + line_step;

   always_comb begin
      init_start = '0;
      init_lines = cols_ff;
      init_len   = rows_ff;
      case (direction_type'(req_pass_direction))
         DIR_FROM_ABOVE: begin
            init_start = '0;
         end
         DIR_FROM_BELOW: begin
            init_start = ADDR_W'(used - USED_W'(cols_ff));
         end
         DIR_FROM_RIGHT: begin
            init_start = ADDR_W'(cols_ff) - ADDR_W'(1);
            init_lines = rows_ff;
            init_len   = cols_ff;
         end
         default: begin
            init_lines = rows_ff;
            init_len   = cols_ff;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      dir_in        = dir_ff;
      addr_in       = addr_ff;
      line_start_in = line_start_ff;
      line_cnt_in   = line_cnt_ff;
      elem_cnt_in   = elem_cnt_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      rd_pend_in    = 1'b0;
      rd_ok_in      = rd_ok_ff;
      mem_we        = 1'b0;
      mem_wa        = addr_ff;
      mem_wd        = blend_value;
      mem_ra        = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            mem_ra = req_addr;
            if (accept) begin
               case (opcode_type'(req_opcode))
                  OP_WRITE: begin
                     mem_we = idx_ok;
                     mem_wa = req_addr;
                     mem_wd = SAMPLE_BITS'(req_sample_value);
                  end
                  OP_READ: begin
                     rd_pend_in = 1'b1;
                     rd_ok_in   = idx_ok;
                  end
                  OP_PASS: begin
                     dir_in = req_pass_direction;
                     if (cols_ff == '0 || rows_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in      = ST_LOAD;
                        addr_in       = init_start;
                        line_start_in = init_start;
                        line_cnt_in   = init_lines - SIDE_W'(1);
                        elem_cnt_in   = init_len - SIDE_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            state_in = ST_PRIME;
         end
         ST_PRIME: begin
            prev_in = rd_data_ff;
            if (elem_cnt_ff != '0) begin
               addr_in  = addr_step;
               state_in = ST_READ;
            end else if (line_cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               line_start_in = next_line_start;
               addr_in       = next_line_start;
               line_cnt_in   = line_cnt_ff - SIDE_W'(1);
               elem_cnt_in   = len_now - SIDE_W'(1);
               state_in      = ST_LOAD;
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cur_in   = rd_data_ff;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_we      = 1'b1;
            prev_in     = blend_value;
            elem_cnt_in = elem_cnt_ff - SIDE_W'(1);
            if (elem_cnt_ff != SIDE_W'(1)) begin
               addr_in  = addr_step;
               state_in = ST_READ;
            end else if (line_cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               line_start_in = next_line_start;
               addr_in       = next_line_start;
               line_cnt_in   = line_cnt_ff - SIDE_W'(1);
               elem_cnt_in   = len_now - SIDE_W'(1);
               state_in      = ST_LOAD;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
         rd_ok_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
         rd_ok_ff   <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff        <= dir_in;
      addr_ff       <= addr_in;
      line_start_ff <= line_start_in;
      line_cnt_ff   <= line_cnt_in;
      elem_cnt_ff   <= elem_cnt_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      prod_ff       <= prod_in;
   end

   // csr registers, saturated on write
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
         cols_ff   <= SIDE_MAX;
         rows_ff   <= SIDE_MAX;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_FACTOR: begin
               factor_ff <= (FACTOR_W'(csr_wdata) > FACTOR_ONE) ?
                            FACTOR_ONE : FACTOR_W'(csr_wdata);
            end
            CSR_COLUMNS: begin
               cols_ff <= (csr_wdata[SIDE_W-1:0] > SIDE_MAX) ?
                          SIDE_MAX : csr_wdata[SIDE_W-1:0];
            end
            CSR_ROWS: begin
               rows_ff <= (csr_wdata[SIDE_W-1:0] > SIDE_MAX) ?
                          SIDE_MAX : csr_wdata[SIDE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // tile store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tile_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= tile_mem[mem_ra];
   end

   assign rsp_valid       = rd_pend_ff || (state_ff == ST_DONE);
   assign rsp_result_kind = (state_ff == ST_DONE) ? KIND_PASS_DONE : KIND_READ_DATA;
   assign rsp_read_value  = (rd_pend_ff && rd_ok_ff) ? VALUE_W'(rd_data_ff) : '0;

   a_read_responds: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_READ) |=> (rsp_valid && !rsp_result_kind))
      else $error("read beat gave no read response");

   a_pass_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_PASS) |=> busy)
      else $error("pass beat did not start the sequencer");

   a_done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (state_ff == ST_IDLE))
      else $error("pass completion did not return to idle");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_IDLE && accept) || state_ff == ST_WRITE))
      else $error("store written outside a write beat or update step");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule : directional_recursive_smoother_unit
`default_nettype wire

>>> tb/smoother_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// smoother_checker
// Watches the request, result and csr channels of the smoother, keeps its own
// copy of the tile and registers, predicts each reply and compares in order.
// ============================================================================
module smoother_checker
   import drs_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       busy,
   input  wire logic [1:0]                 req_opcode,
   input  wire logic [1:0]                 req_pass_direction,
   input  wire logic [INDEX_W-1:0]         req_sample_index,
   input  wire logic signed [VALUE_W-1:0]  req_sample_value,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_result_kind,
   input  wire logic signed [VALUE_W-1:0]  rsp_read_value,
   input  wire logic                       csr_valid,
   input  wire logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wdata,
   output int                              failures,
   output int                              outstanding
);

   typedef struct packed {
      result_kind_type     kind;
      logic [VALUE_W-1:0]  value;
   } reply_type;

   logic signed [VALUE_W-1:0] heights [STORE_DEPTH];
   logic [FACTOR_W-1:0]       weight;
   int                        tile_cols;
   int                        tile_rows;
   reply_type                 replies_due [$];

   // cur + floor(weight * (prev - cur) / 2^F)
   function automatic void blend_into(input int dst, input int src);
      longint diff;
      longint scaled;
      diff   = longint'(heights[src]) - longint'(heights[dst]);
      scaled = diff * longint'({47'd0, weight});
      heights[dst] = VALUE_W'(longint'(heights[dst]) + (scaled >>> FACTOR_FRAC_BITS));
   endfunction

   function automatic void smooth_tile(input direction_type dir);
      int w;
      int h;
      w = tile_cols;
      h = tile_rows;
      if (w == 0 || h == 0) return;
      case (dir)
         DIR_FROM_ABOVE: begin
            for (int j = 0; j < w; j++)
               for (int i = 1; i < h; i++) blend_into(i * w + j, (i - 1) * w + j);
         end
         DIR_FROM_BELOW: begin
            for (int j = 0; j < w; j++)
               for (int i = h - 1; i > 0; i--) blend_into((i - 1) * w + j, i * w + j);
         end
         DIR_FROM_RIGHT: begin
            for (int i = 0; i < h; i++)
               for (int j = w - 1; j > 0; j--) blend_into(i * w + j - 1, i * w + j);
         end
         default: begin
            for (int i = 0; i < h; i++)
               for (int j = 1; j < w; j++) blend_into(i * w + j, i * w + j - 1);
         end
      endcase
   endfunction

   always @(posedge clock) begin : track
      reply_type due;
      int        used;
      if (reset) begin
         weight    = FACTOR_RESET;
         tile_cols = MAX_SIDE;
         tile_rows = MAX_SIDE;
         replies_due.delete();
      end else begin
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected result beat: kind %0d value %h",
                           rsp_result_kind, rsp_read_value);
            end else begin
               due = replies_due.pop_front();
               if (rsp_result_kind !== due.kind || rsp_read_value !== due.value) begin
                  failures++;
                  if (failures <= 10)
                     $display("result mismatch: expected kind %0d value %h, %s %0d value %h",
                              due.kind, due.value, "got kind",
                              rsp_result_kind, rsp_read_value);
               end
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_FACTOR:  weight = (csr_wdata > FACTOR_ONE) ? FACTOR_ONE : csr_wdata;
               CSR_COLUMNS: tile_cols = (csr_wdata[8:0] > MAX_SIDE) ? MAX_SIDE : csr_wdata[8:0];
               CSR_ROWS:    tile_rows = (csr_wdata[8:0] > MAX_SIDE) ? MAX_SIDE : csr_wdata[8:0];
               default: ;
            endcase
         end

         if (start && !busy) begin
            used = tile_cols * tile_rows;
            case (opcode_type'(req_opcode))
               OP_WRITE: begin
                  if (req_sample_index < used) heights[req_sample_index] = req_sample_value;
               end
               OP_PASS: begin
                  smooth_tile(direction_type'(req_pass_direction));
                  due.kind  = KIND_PASS_DONE;
                  due.value = '0;
                  replies_due = {replies_due, due};
               end
               OP_READ: begin
                  due.kind  = KIND_READ_DATA;
                  due.value = (req_sample_index < used) ? heights[req_sample_index] : '0;
                  replies_due = {replies_due, due};
               end
               default: ;
            endcase
         end
      end
      outstanding <= replies_due.size();
   end

endmodule : smoother_checker

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Drives loads, reads and smoothing passes into the smoother over a range of
// factors and tile shapes, with random sender gaps; the checker judges beats.
// ============================================================================
module testbench;
   import drs_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [1:0]                 req_opcode = OP_WRITE;
   logic [1:0]                 req_pass_direction = DIR_FROM_ABOVE;
   logic [INDEX_W-1:0]         req_sample_index = '0;
   logic signed [VALUE_W-1:0]  req_sample_value = '0;
   logic                       rsp_valid;
   logic                       rsp_result_kind;
   logic signed [VALUE_W-1:0]  rsp_read_value;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = CSR_FACTOR;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;
   int                         failures;
   int                         outstanding;

   int idle_pct = 37;
   int sent = 0;
   int tile_cols = MAX_SIDE;
   int tile_rows = MAX_SIDE;
   int cycle_count = 0;

   directional_recursive_smoother_unit uut (.*);
   smoother_checker scoreboard (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [31:0] random_height();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // mostly in range, sometimes past the tile in use
   function automatic logic [15:0] pick_index(input int used);
      if (used > 0 && (used == STORE_DEPTH || $urandom_range(9) != 0))
         return 16'($urandom_range(used - 1, 0));
      return 16'($urandom_range(65535, used));
   endfunction

   function automatic int side_of(input logic [8:0] v);
      return (v > MAX_SIDE) ? MAX_SIDE : v;
   endfunction

   task automatic send_item(input opcode_type op, input direction_type dir,
                            input logic [15:0] idx, input logic [31:0] value);
      idle_pct = (sent < 150) ? 37 : (sent < 300) ? 55 : 0;
      sent++;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_opcode         <= op;
      req_pass_direction <= dir;
      req_sample_index   <= idx;
      req_sample_value   <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type which, input logic [16:0] data);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_tile(input logic [16:0] factor, input logic [8:0] cols,
                           input logic [8:0] rows);
      wait_idle();
      write_csr(CSR_FACTOR, factor);
      write_csr(CSR_COLUMNS, {8'($urandom), cols});
      write_csr(CSR_ROWS, {8'($urandom), rows});
      if ($urandom_range(3) == 0) write_csr(CSR_UNUSED, 17'($urandom));
      tile_cols = side_of(cols);
      tile_rows = side_of(rows);
   endtask

   task automatic load_tile();
      for (int i = 0; i < tile_cols * tile_rows; i++)
         send_item(OP_WRITE, direction_type'($urandom_range(3)), 16'(i), random_height());
   endtask

   initial begin : stimulus
      int           pick;
      int           shape;
      logic [16:0]  factor;
      logic [8:0]   cols;
      logic [8:0]   rows;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset shape: whole store in range
      send_item(OP_WRITE, DIR_FROM_ABOVE, 16'd0, 32'h7FFF_FFFF);
      send_item(OP_WRITE, DIR_FROM_LEFT, 16'hFFFF, 32'h8000_0000);
      send_item(OP_READ, DIR_FROM_BELOW, 16'd0, 32'h0);
      send_item(OP_READ, DIR_FROM_RIGHT, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(OP_NONE, DIR_FROM_RIGHT, 16'hFFFF, 32'hFFFF_FFFF);
      wait_idle();
      write_csr(CSR_UNUSED, 17'h1FFFF);

      set_tile(17'd32768, 9'd4, 9'd3);
      load_tile();
      send_item(OP_WRITE, DIR_FROM_ABOVE, 16'd12, 32'hFFFF_FFFF);
      send_item(OP_WRITE, DIR_FROM_BELOW, 16'hFFFF, 32'h1234_5678);
      send_item(OP_READ, DIR_FROM_ABOVE, 16'd12, 32'h0);
      send_item(OP_READ, DIR_FROM_ABOVE, 16'hFFFF, 32'h0);
      for (int d = 0; d < 4; d++) send_item(OP_PASS, direction_type'(d), 16'd0, 32'h0);
      send_item(OP_READ, DIR_FROM_LEFT, 16'd11, 32'h0);

      // no weight, full weight, saturated weight
      set_tile(17'd0, 9'd4, 9'd3);
      send_item(OP_PASS, direction_type'($urandom_range(3)), 16'd0, 32'h0);
      set_tile(17'd65536, 9'd4, 9'd3);
      send_item(OP_PASS, direction_type'($urandom_range(3)), 16'd0, 32'h0);
      set_tile(17'h1FFFF, 9'd4, 9'd3);
      send_item(OP_PASS, direction_type'($urandom_range(3)), 16'd0, 32'h0);

      // saturated sides; the first 256 entries stay loaded from here on
      set_tile(17'd32768, 9'd511, 9'd1);
      load_tile();
      send_item(OP_PASS, DIR_FROM_LEFT, 16'd0, 32'h0);
      send_item(OP_PASS, DIR_FROM_RIGHT, 16'd0, 32'h0);
      send_item(OP_READ, DIR_FROM_ABOVE, 16'd255, 32'h0);
      set_tile(17'd20000, 9'd1, 9'd300);
      send_item(OP_PASS, DIR_FROM_ABOVE, 16'd0, 32'h0);
      send_item(OP_PASS, DIR_FROM_BELOW, 16'd0, 32'h0);
      send_item(OP_READ, DIR_FROM_ABOVE, 16'd255, 32'h0);

      // empty tile
      set_tile(17'd32768, 9'd0, 9'd5);
      send_item(OP_PASS, DIR_FROM_LEFT, 16'd0, 32'h0);
      send_item(OP_READ, DIR_FROM_ABOVE, 16'd0, 32'h0);
      send_item(OP_WRITE, DIR_FROM_ABOVE, 16'd0, 32'h5555_AAAA);

      while (sent < 450) begin
         case ($urandom_range(5))
            0: factor = 17'd0;
            1: factor = 17'd65536;
            2: factor = 17'($urandom_range(131071, 65537));
            default: factor = 17'($urandom_range(65535, 0));
         endcase
         shape = $urandom_range(15);
         if (shape == 0) begin
            cols = 9'($urandom_range(511, 256));
            rows = 9'd1;
         end else if (shape == 1) begin
            cols = 9'd1;
            rows = 9'($urandom_range(511, 256));
         end else if (shape == 2) begin
            cols = 9'($urandom_range(3));
            rows = (cols == 0) ? 9'($urandom_range(8)) : 9'd0;
         end else begin
            cols = 9'($urandom_range(8, 1));
            rows = 9'($urandom_range(8, 1));
         end
         set_tile(factor, cols, rows);
         repeat ($urandom_range(40, 15)) begin
            pick = $urandom_range(99);
            if (pick < 8)
               send_item(OP_NONE, direction_type'($urandom_range(3)), 16'($urandom), $urandom);
            else if (pick < 40)
               send_item(OP_WRITE, direction_type'($urandom_range(3)),
                         pick_index(tile_cols * tile_rows), random_height());
            else if (pick < 75)
               send_item(OP_READ, direction_type'($urandom_range(3)),
                         pick_index(tile_cols * tile_rows), $urandom);
            else
               send_item(OP_PASS, direction_type'($urandom_range(3)),
                         16'($urandom), $urandom);
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule : testbench
